@@ rtl/core/atlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// atlc_pkg
// types, sizes and helpers of the tag authorization list and cache
// ---------------------------------------------------------------------------
package atlc_pkg;

  localparam int unsigned LIST_N    = 32;
  localparam int unsigned CACHE_N   = 16;
  localparam int unsigned TAG_BYTES = 20;

  localparam int unsigned LIDX_W = (LIST_N > 1) ? $clog2(LIST_N) : 1;
  localparam int unsigned CIDX_W = (CACHE_N > 1) ? $clog2(CACHE_N) : 1;
  localparam int unsigned IDX_W  = (LIDX_W > CIDX_W) ? LIDX_W : CIDX_W;
  localparam int unsigned SCAN_W = IDX_W + 1;
  localparam int unsigned CNT_W  = $clog2(LIST_N + 1);

  localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
  localparam logic [2:0] STATUS_EXPIRED  = 3'd2;

  typedef enum logic [2:0] {
    ACT_BEGIN  = 3'd0,
    ACT_PUT    = 3'd1,
    ACT_COMMIT = 3'd2,
    ACT_ABORT  = 3'd3,
    ACT_CPUT   = 3'd4,
    ACT_CCLR   = 3'd5,
    ACT_LOOKUP = 3'd6,
    ACT_NONE   = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_SCAN,
    S_FIN,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [31:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } key_t;

  typedef struct packed {
    key_t        key;
    key_t        par;
    logic [2:0]  st;
    logic [31:0] exp;
  } entry_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [63:0]        tag_w0;
    logic [63:0]        tag_w1;
    logic [31:0]        tag_w2;
    logic [63:0]        parent_w0;
    logic [63:0]        parent_w1;
    logic [31:0]        parent_w2;
    logic [2:0]         status_in;
    logic [31:0]        expiry_in;
    logic [31:0]        now_time;
    logic               mode_flag;
    logic signed [31:0] version_in;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [2:0]         status_out;
    logic [63:0]        parent_out_w0;
    logic [63:0]        parent_out_w1;
    logic [31:0]        parent_out_w2;
    logic [31:0]        expiry_out;
    logic signed [31:0] list_version;
    logic [5:0]         list_count;
    logic               update_active;
  } out_t;

  // clear the first zero byte, everything after it and bytes past TAG_BYTES
  function automatic key_t canon(input logic [63:0] w0, input logic [63:0] w1,
                                 input logic [31:0] w2);
    logic [159:0] raw;
    logic [159:0] res;
    logic         ended;
    raw   = {w2, w1, w0};
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < 20; k++) begin
      if (k >= TAG_BYTES || raw[8*k +: 8] == 8'd0) ended = 1'b1;
      if (!ended) res[8*k +: 8] = raw[8*k +: 8];
    end
    return key_t'(res);
  endfunction

  function automatic logic expired(input logic [31:0] e, input logic [31:0] now);
    return (e != 32'd0) && (now != 32'd0) && (now > e);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/auth_tag_list_and_cache.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// auth_tag_list_and_cache
// tag authorization table: live list, staging list and cache in sync memories
// ---------------------------------------------------------------------------
// Usage: one item in on in_valid_i/in_ready_o, one result item out on
// out_valid_o/out_ready_i for every item, in order. in_ready_o is high only
// while no item is in work; a finished result sits in the output register,
// so the next item is taken while that result still waits.
// The live and staging lists are two banks of one 64-entry memory (one read,
// one write port, registered read); commit swaps banks. Entry valid bits and
// list counts are flip-flops.
// Steps per item: commit, abort, cache clear, empty begin, puts without
// staging, and cache puts or lookups with an empty tag go straight to the
// result. Put and cache put scan the memory one entry a cycle. Begin with
// copy sweeps all 32 entries. Lookup scans the live list and, when it
// misses there and mode_flag is set, falls through to the cache.
// Reset empties live list and cache, zeroes the version and closes staging;
// no clearing pass is needed. A stalled receiver holds the finished result in
// the output register and the block waits before it delivers the next one.
// ---------------------------------------------------------------------------
module auth_tag_list_and_cache (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic                     in_ready_o,
  input  wire atlc_pkg::in_t       in_data_i,
  output logic                     out_valid_o,
  input  wire                logic out_ready_i,
  output atlc_pkg::out_t           out_data_o
);

  localparam int unsigned LN   = atlc_pkg::LIST_N;
  localparam int unsigned CN   = atlc_pkg::CACHE_N;
  localparam int unsigned LW   = atlc_pkg::LIDX_W;
  localparam int unsigned CW   = atlc_pkg::CIDX_W;
  localparam int unsigned IW   = atlc_pkg::IDX_W;
  localparam int unsigned SW   = atlc_pkg::SCAN_W;
  localparam int unsigned NW   = atlc_pkg::CNT_W;

  atlc_pkg::fsm_e state_q, state_d;

  logic                      sel_q;
  logic                      open_q;
  logic signed [31:0]        live_ver_q;
  logic signed [31:0]        stg_ver_q;
  logic [1:0][LN-1:0]        lvld_q;
  logic [CN-1:0]             cvld_q;
  logic [1:0][NW-1:0]        cnt_q;

  atlc_pkg::action_e         act_q;
  atlc_pkg::key_t            tag_q;
  atlc_pkg::key_t            par_q;
  logic [2:0]                sti_q;
  logic [31:0]               exp_q;
  logic [31:0]               now_q;
  logic                      flag_q;

  logic                      scan_cache_q;
  logic                      scan_bank_q;
  logic [SW-1:0]             rd_idx_q;
  logic                      pend_q;
  logic [IW-1:0]             pend_idx_q;
  logic                      hit_q;
  logic [IW-1:0]             hit_idx_q;
  atlc_pkg::entry_t          hit_ent_q;
  logic                      free_q;
  logic [IW-1:0]             free_idx_q;

  logic                      ok_q;
  logic [2:0]                res_st_q;
  atlc_pkg::key_t            res_par_q;
  logic [31:0]               res_exp_q;

  logic                      out_valid_q;
  atlc_pkg::out_t            out_q;

  atlc_pkg::entry_t          lmem [2*LN];
  atlc_pkg::entry_t          cmem [CN];
  atlc_pkg::entry_t          lrd_q;
  atlc_pkg::entry_t          crd_q;

  logic [LW:0]               l_raddr;
  logic                      l_we;
  logic [LW:0]               l_waddr;
  atlc_pkg::entry_t          l_wdata;
  logic [CW-1:0]             c_raddr;
  logic                      c_we;
  logic [CW-1:0]             c_waddr;
  atlc_pkg::entry_t          c_wdata;

  logic                      in_acc;
  logic                      out_load;
  atlc_pkg::key_t            tag_c;
  atlc_pkg::key_t            par_c;
  atlc_pkg::action_e         act_c;
  logic [SW-1:0]             scan_lim;
  logic                      issue;
  atlc_pkg::entry_t          cmp_ent;
  logic                      cmp_vld;
  logic                      cmp_hit;
  logic                      scan_end;
  logic                      copy_end;
  atlc_pkg::entry_t          new_ent;
  logic [CW-1:0]             c_slot;

  assign tag_c    = atlc_pkg::canon(in_data_i.tag_w0, in_data_i.tag_w1, in_data_i.tag_w2);
  assign par_c    = atlc_pkg::canon(in_data_i.parent_w0, in_data_i.parent_w1,
                                    in_data_i.parent_w2);
  assign act_c    = atlc_pkg::action_e'(in_data_i.action);
  assign in_ready_o = (state_q == atlc_pkg::S_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_load = (state_q == atlc_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  assign scan_lim = scan_cache_q ? SW'(CN) : SW'(LN);
  assign issue    = (rd_idx_q < scan_lim) &&
                    (state_q == atlc_pkg::S_COPY || state_q == atlc_pkg::S_SCAN);
  assign cmp_ent  = scan_cache_q ? crd_q : lrd_q;
  assign cmp_vld  = scan_cache_q ? cvld_q[pend_idx_q[CW-1:0]]
                                 : lvld_q[scan_bank_q][pend_idx_q[LW-1:0]];
  assign cmp_hit  = (state_q == atlc_pkg::S_SCAN) && pend_q && cmp_vld &&
                    (cmp_ent.key == tag_q);
  assign scan_end = cmp_hit || (rd_idx_q == scan_lim && !pend_q);
  assign copy_end = (rd_idx_q == SW'(LN)) && !pend_q;

  assign new_ent  = '{key: tag_q, par: par_q, st: sti_q, exp: exp_q};
  assign c_slot   = hit_q ? hit_idx_q[CW-1:0] : (free_q ? free_idx_q[CW-1:0] : '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      atlc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (act_c)
            atlc_pkg::ACT_BEGIN: begin
              state_d = in_data_i.mode_flag ? atlc_pkg::S_DONE : atlc_pkg::S_COPY;
            end
            atlc_pkg::ACT_PUT: begin
              state_d = open_q ? atlc_pkg::S_SCAN : atlc_pkg::S_DONE;
            end
            atlc_pkg::ACT_CPUT, atlc_pkg::ACT_LOOKUP: begin
              state_d = (tag_c.w0 != 64'd0) ? atlc_pkg::S_SCAN : atlc_pkg::S_DONE;
            end
            default: begin
              state_d = atlc_pkg::S_DONE;
            end
          endcase
        end
      end
      atlc_pkg::S_COPY: begin
        if (copy_end) state_d = atlc_pkg::S_DONE;
      end
      atlc_pkg::S_SCAN: begin
        if (scan_end) state_d = atlc_pkg::S_FIN;
      end
      atlc_pkg::S_FIN: begin
        if (act_q == atlc_pkg::ACT_LOOKUP && !scan_cache_q && !hit_q && flag_q) begin
          state_d = atlc_pkg::S_SCAN;
        end else begin
          state_d = atlc_pkg::S_DONE;
        end
      end
      atlc_pkg::S_DONE: begin
        if (out_load) state_d = atlc_pkg::S_IDLE;
      end
      default: begin
        state_d = atlc_pkg::S_IDLE;
      end
    endcase
  end

  // memory controls
  always_comb begin
    l_raddr = {scan_bank_q, rd_idx_q[LW-1:0]};
    c_raddr = rd_idx_q[CW-1:0];
    l_we    = 1'b0;
    l_waddr = {~scan_bank_q, pend_idx_q[LW-1:0]};
    l_wdata = lrd_q;
    c_we    = 1'b0;
    c_waddr = c_slot;
    c_wdata = new_ent;
    if (state_q == atlc_pkg::S_COPY && pend_q) begin
      l_we = 1'b1;
    end else if (state_q == atlc_pkg::S_FIN && act_q == atlc_pkg::ACT_PUT && !flag_q &&
                 (hit_q || free_q)) begin
      l_we    = 1'b1;
      l_waddr = {scan_bank_q, hit_q ? hit_idx_q[LW-1:0] : free_idx_q[LW-1:0]};
      l_wdata = new_ent;
    end
    if (state_q == atlc_pkg::S_FIN && act_q == atlc_pkg::ACT_CPUT) begin
      c_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (l_we) lmem[l_waddr] <= l_wdata;
    lrd_q <= lmem[l_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    crd_q <= cmem[c_raddr];
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= act_c;
      tag_q  <= tag_c;
      par_q  <= par_c;
      sti_q  <= in_data_i.status_in;
      exp_q  <= in_data_i.expiry_in;
      now_q  <= in_data_i.now_time;
      flag_q <= in_data_i.mode_flag;
    end
  end

  // control, scan and table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= atlc_pkg::S_IDLE;
      sel_q        <= 1'b0;
      open_q       <= 1'b0;
      live_ver_q   <= '0;
      stg_ver_q    <= '0;
      lvld_q       <= '0;
      cvld_q       <= '0;
      cnt_q        <= '0;
      scan_cache_q <= 1'b0;
      scan_bank_q  <= 1'b0;
      rd_idx_q     <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_ent_q    <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
      ok_q         <= 1'b0;
      res_st_q     <= '0;
      res_par_q    <= '0;
      res_exp_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        rd_idx_q     <= '0;
        pend_q       <= 1'b0;
        hit_q        <= 1'b0;
        free_q       <= 1'b0;
        scan_cache_q <= (act_c == atlc_pkg::ACT_CPUT);
        scan_bank_q  <= (act_c == atlc_pkg::ACT_PUT) ? ~sel_q : sel_q;
        ok_q         <= 1'b0;
        res_st_q     <= '0;
        res_par_q    <= '0;
        res_exp_q    <= '0;
        case (act_c)
          atlc_pkg::ACT_BEGIN: begin
            stg_ver_q <= in_data_i.version_in;
            open_q    <= 1'b1;
            ok_q      <= 1'b1;
            lvld_q[~sel_q] <= in_data_i.mode_flag ? '0 : lvld_q[sel_q];
            cnt_q[~sel_q]  <= in_data_i.mode_flag ? '0 : cnt_q[sel_q];
          end
          atlc_pkg::ACT_COMMIT: begin
            if (open_q) begin
              sel_q      <= ~sel_q;
              live_ver_q <= stg_ver_q;
              open_q     <= 1'b0;
              ok_q       <= 1'b1;
            end
          end
          atlc_pkg::ACT_ABORT: begin
            open_q <= 1'b0;
            ok_q   <= 1'b1;
          end
          atlc_pkg::ACT_CCLR: begin
            cvld_q <= '0;
            ok_q   <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (issue) begin
        rd_idx_q   <= rd_idx_q + SW'(1);
        pend_idx_q <= rd_idx_q[IW-1:0];
      end
      if (state_q == atlc_pkg::S_COPY || state_q == atlc_pkg::S_SCAN) begin
        pend_q <= issue && !(state_q == atlc_pkg::S_SCAN && cmp_hit);
      end
      if (cmp_hit) begin
        hit_q     <= 1'b1;
        hit_idx_q <= pend_idx_q;
        hit_ent_q <= cmp_ent;
      end
      if (state_q == atlc_pkg::S_SCAN && pend_q && !cmp_vld && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= pend_idx_q;
      end
      if (state_q == atlc_pkg::S_FIN) begin
        case (act_q)
          atlc_pkg::ACT_PUT: begin
            if (flag_q) begin
              ok_q <= 1'b1;
              if (hit_q) begin
                lvld_q[scan_bank_q][hit_idx_q[LW-1:0]] <= 1'b0;
                cnt_q[scan_bank_q] <= cnt_q[scan_bank_q] - NW'(1);
              end
            end else if (hit_q) begin
              ok_q <= 1'b1;
            end else if (free_q) begin
              ok_q <= 1'b1;
              lvld_q[scan_bank_q][free_idx_q[LW-1:0]] <= 1'b1;
              cnt_q[scan_bank_q] <= cnt_q[scan_bank_q] + NW'(1);
            end
          end
          atlc_pkg::ACT_CPUT: begin
            cvld_q[c_slot] <= 1'b1;
            ok_q           <= 1'b1;
          end
          atlc_pkg::ACT_LOOKUP: begin
            if (!scan_cache_q) begin
              if (hit_q) begin
                ok_q      <= 1'b1;
                res_par_q <= hit_ent_q.par;
                res_exp_q <= hit_ent_q.exp;
                res_st_q  <= (hit_ent_q.st == atlc_pkg::STATUS_ACCEPTED &&
                              atlc_pkg::expired(hit_ent_q.exp, now_q)) ?
                             atlc_pkg::STATUS_EXPIRED : hit_ent_q.st;
              end else if (flag_q) begin
                scan_cache_q <= 1'b1;
                rd_idx_q     <= '0;
                pend_q       <= 1'b0;
                free_q       <= 1'b0;
              end
            end else if (hit_q && !atlc_pkg::expired(hit_ent_q.exp, now_q)) begin
              ok_q      <= 1'b1;
              res_par_q <= hit_ent_q.par;
              res_exp_q <= hit_ent_q.exp;
              res_st_q  <= hit_ent_q.st;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.ok            <= ok_q;
      out_q.status_out    <= res_st_q;
      out_q.parent_out_w0 <= res_par_q.w0;
      out_q.parent_out_w1 <= res_par_q.w1;
      out_q.parent_out_w2 <= res_par_q.w2;
      out_q.expiry_out    <= res_exp_q;
      out_q.list_version  <= live_ver_q;
      out_q.list_count    <= 6'(cnt_q[sel_q]);
      out_q.update_active <= open_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_write_stage_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l_we |-> (l_waddr[LW] != sel_q))
    else $error("list write hit the live bank");

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(lvld_q[sel_q]) == int'(cnt_q[sel_q]))
    else $error("live count out of step with valid bits");

  a_stage_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(lvld_q[~sel_q]) == int'(cnt_q[~sel_q]))
    else $error("staging count out of step with valid bits");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atlc_pkg::S_SCAN || state_q == atlc_pkg::S_COPY) |-> rd_idx_q <= scan_lim)
    else $error("scan index past end");

  a_copy_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == atlc_pkg::S_COPY |-> open_q)
    else $error("copy running without staging");

endmodule
`default_nettype wire
